// ----- rtl/cepstrum_to_group_delay_assert.svh -----
// assertion macros for the cepstrum to group delay block
`ifndef CEPSTRUM_TO_GROUP_DELAY_ASSERT_SVH
`define CEPSTRUM_TO_GROUP_DELAY_ASSERT_SVH

`ifndef SYNTHESIS
// property checked on every rising clock edge outside reset
`define CGD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cgd assertion failed");
// condition that must never be seen outside reset
`define CGD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("cgd forbidden condition seen");
`else
`define CGD_ASSERT(lbl, clk, rst_n, prop)
`define CGD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ----- rtl/cgd_pkg.sv -----
`default_nettype none

package cgd_pkg;

    // field widths
    localparam int INDEX_W  = 10;
    localparam int COEF_W   = 24;
    localparam int VALUE_W  = 48;
    localparam int ORDER_W  = 10;
    localparam int LOG2_W   = 4;
    localparam int COS_W    = 17;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // parameter defaults
    localparam int DEF_MAX_ORDER    = 512;
    localparam int DEF_MAX_LOG2_FFT = 10;

    // register reset values
    localparam logic [ORDER_W-1:0] ORDER_RESET = 10'd25;
    localparam logic [LOG2_W-1:0]  LOG2_RESET  = 4'd8;

    // register indexes (word address bit 2)
    localparam logic [0:0] REG_ORDER = 1'b0;
    localparam logic [0:0] REG_LOG2  = 1'b1;

    typedef enum logic [0:0] {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } t_cgd_kind;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_CFG_INVALID = 2'd1,
        STATUS_RANGE       = 2'd2
    } t_cgd_status;

    typedef enum logic [1:0] {
        CGD_IDLE,
        CGD_RUN,
        CGD_DRAIN
    } t_cgd_state;

    typedef struct packed {
        t_cgd_kind                 kind;
        logic [INDEX_W-1:0]        index;
        logic signed [COEF_W-1:0]  coef;
    } t_cgd_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        t_cgd_status               status;
    } t_cgd_res;

endpackage

`default_nettype wire

// ----- rtl/cgd_cos_rom.sv -----
`default_nettype none

module cgd_cos_rom #(
    parameter int MAX_LOG2_FFT = cgd_pkg::DEF_MAX_LOG2_FFT
) (
    input  wire logic                      i_clk,
    input  wire logic [MAX_LOG2_FFT-1:0]   i_phase,
    output logic [cgd_pkg::COS_W-1:0]      o_mag,
    output logic                           o_neg
);

    localparam int LOG     = MAX_LOG2_FFT;
    localparam int QUARTER = (1 << LOG) / 4;
    localparam int AW      = (QUARTER + 1 > 1) ? $clog2(QUARTER + 1) : 1;
    localparam int PW      = LOG + 1;
    localparam longint PI_Q30  = 64'sd3373259426;
    localparam longint ONE_Q30 = 64'sd1073741824;

    logic [cgd_pkg::COS_W-1:0] w_tab [QUARTER+1];

    // constant quarter-wave table, q1.16, from an eleven-term sine or cosine series in q30
    for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_tab
        // upper half of the quarter uses the sine of the complementary angle
        localparam bit     ODD = (2 * gi > QUARTER);
        localparam longint ANG = ODD ? ((PI_Q30 * longint'(QUARTER - gi)) >>> (LOG - 1))
                                     : ((PI_Q30 * longint'(gi)) >>> (LOG - 1));
        localparam longint X2  = (ANG * ANG) >>> 30;
        localparam longint T0  = ODD ? ANG : ONE_Q30;
        localparam longint T1  = ((T0 * X2) >>> 30) / (ODD ? 64'sd6 : 64'sd2);
        localparam longint T2  = ((T1 * X2) >>> 30) / (ODD ? 64'sd20 : 64'sd12);
        localparam longint T3  = ((T2 * X2) >>> 30) / (ODD ? 64'sd42 : 64'sd30);
        localparam longint T4  = ((T3 * X2) >>> 30) / (ODD ? 64'sd72 : 64'sd56);
        localparam longint T5  = ((T4 * X2) >>> 30) / (ODD ? 64'sd110 : 64'sd90);
        localparam longint T6  = ((T5 * X2) >>> 30) / (ODD ? 64'sd156 : 64'sd132);
        localparam longint T7  = ((T6 * X2) >>> 30) / (ODD ? 64'sd210 : 64'sd182);
        localparam longint T8  = ((T7 * X2) >>> 30) / (ODD ? 64'sd272 : 64'sd240);
        localparam longint T9  = ((T8 * X2) >>> 30) / (ODD ? 64'sd342 : 64'sd306);
        localparam longint T10 = ((T9 * X2) >>> 30) / (ODD ? 64'sd420 : 64'sd380);
        localparam longint SUM = T0 - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9 + T10;
        localparam longint POS = (SUM < 0) ? 64'sd0 : SUM;
        localparam longint RND = (POS + 64'sd8192) >>> 14;
        localparam longint CLP = (RND > 64'sd65536) ? 64'sd65536 : RND;
        localparam logic [cgd_pkg::COS_W-1:0] ENTRY = cgd_pkg::COS_W'(CLP);
        assign w_tab[gi] = ENTRY;
    end

    logic [PW-1:0] w_ph;
    logic [PW-1:0] w_addr_full;
    logic [AW-1:0] w_addr;
    logic          w_neg;

    // fold the full-wave phase onto the quarter table
    always_comb begin
        w_ph = PW'(i_phase);
        if (w_ph <= PW'(QUARTER)) begin
            w_addr_full = w_ph;
            w_neg       = 1'b0;
        end else if (w_ph <= PW'(2 * QUARTER)) begin
            w_addr_full = PW'(2 * QUARTER) - w_ph;
            w_neg       = 1'b1;
        end else if (w_ph <= PW'(3 * QUARTER)) begin
            w_addr_full = w_ph - PW'(2 * QUARTER);
            w_neg       = 1'b1;
        end else begin
            w_addr_full = PW'(4 * QUARTER) - w_ph;
            w_neg       = 1'b0;
        end
        w_addr = w_addr_full[AW-1:0];
    end

    // registered table read
    always_ff @(posedge i_clk) begin
        o_mag <= w_tab[w_addr];
        o_neg <= w_neg;
    end

endmodule

`default_nettype wire

// ----- rtl/cepstrum_to_group_delay.sv -----
`default_nettype none
// channel   | direction | handshake                      | payload
// ----------+-----------+--------------------------------+-------------------------
// request   | in        | start high while busy low      | i_request (t_cgd_req)
// result    | out       | o_done strobe, one cycle       | o_result  (t_cgd_res)
// config    | in/out    | apb write: psel penable pwrite | paddr, pwdata, prdata
//
// a load request gives its result in the cycle after it is taken and busy stays low.
// a bin request runs one multiply-accumulate per coefficient through a four-stage pipe
// (store and cosine reads, m*c, times cosine, round and add): the strobe comes
// once the last term has been added and the pipe is empty, busy is high throughout.
// rejected bin requests and order zero answer in the next cycle like loads.
// synchronous active-low reset restores order 25 and length 2^8; store stays undefined.
// results cannot be held off: o_done marks each with a one-cycle strobe, and o_result holds it until the next accept.

module cepstrum_to_group_delay #(
    parameter int MAX_ORDER    = cgd_pkg::DEF_MAX_ORDER,
    parameter int MAX_LOG2_FFT = cgd_pkg::DEF_MAX_LOG2_FFT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire cgd_pkg::t_cgd_req             i_request,
    output logic                               o_done,
    output cgd_pkg::t_cgd_res                  o_result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cgd_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [cgd_pkg::PDATA_W-1:0]   pwdata,
    output logic [cgd_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

`include "cepstrum_to_group_delay_assert.svh"

    localparam int LOG     = MAX_LOG2_FFT;
    localparam int MW      = $clog2(MAX_ORDER + 1);
    localparam int CMPW    = MW + cgd_pkg::ORDER_W;
    localparam int NW      = 17;
    localparam int P1_W    = MW + 1 + cgd_pkg::COEF_W;
    localparam int COSS_W  = cgd_pkg::COS_W + 1;
    localparam int P2_W    = P1_W + COSS_W;
    localparam int TERM_W  = P2_W - 16;
    localparam int ACC_W   = TERM_W + MW;
    localparam int EXT_W   = ((ACC_W > cgd_pkg::VALUE_W) ? ACC_W : cgd_pkg::VALUE_W) + 1;
    localparam logic signed [EXT_W-1:0] VMAX = (EXT_W'(1) <<< (cgd_pkg::VALUE_W - 1)) - 1;
    localparam logic signed [EXT_W-1:0] VMIN = -VMAX - 1;

    // configuration registers
    logic [cgd_pkg::ORDER_W-1:0] r_order;
    logic [cgd_pkg::LOG2_W-1:0]  r_log2;
    logic                        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= cgd_pkg::ORDER_RESET;
            r_log2  <= cgd_pkg::LOG2_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                cgd_pkg::REG_ORDER: r_order <= pwdata[cgd_pkg::ORDER_W-1:0];
                cgd_pkg::REG_LOG2:  r_log2  <= pwdata[cgd_pkg::LOG2_W-1:0];
                default:            r_order <= r_order;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[2])
            cgd_pkg::REG_ORDER: prdata = cgd_pkg::PDATA_W'(r_order);
            cgd_pkg::REG_LOG2:  prdata = cgd_pkg::PDATA_W'(r_log2);
            default:            prdata = '0;
        endcase
    end

    // sequencer registers
    cgd_pkg::t_cgd_state r_state, n_state;
    logic [MW-1:0]       r_m, n_m;
    logic [LOG-1:0]      r_phase, n_phase;
    logic [LOG-1:0]      r_step, n_step;
    logic                r_done, n_done;
    cgd_pkg::t_cgd_res   r_res, n_res;
    logic                w_acc_clr;
    logic                w_we;
    logic                w_issue;

    // pipeline registers
    logic                        r_vb, r_vc, r_vd;
    logic [MW-1:0]               r_m_b;
    logic signed [cgd_pkg::COEF_W-1:0] r_c;
    logic signed [P1_W-1:0]      r_p1;
    logic signed [COSS_W-1:0]    r_cos_c;
    logic signed [P2_W-1:0]      r_p2;
    logic signed [ACC_W-1:0]     r_acc;
    logic [cgd_pkg::COS_W-1:0]   w_cos_mag;
    logic                        w_cos_neg;

    // request decode
    logic                  w_accept;
    logic [NW-1:0]         w_n;
    logic                  w_cfg_bad;
    logic                  w_bin_bad;
    logic                  w_load_bad;
    logic [cgd_pkg::LOG2_W-1:0] w_shift;
    logic [LOG-1:0]        w_idx_ph;
    logic [LOG-1:0]        w_step;
    logic [MW-1:0]         w_order_m;

    assign busy      = (r_state != cgd_pkg::CGD_IDLE);
    assign w_accept  = start && !busy;
    assign w_n       = NW'(1) << r_log2;
    assign w_cfg_bad = (r_log2 == '0)
                    || (r_log2 > cgd_pkg::LOG2_W'(MAX_LOG2_FFT))
                    || (CMPW'(r_order) > CMPW'(MAX_ORDER))
                    || (w_n < NW'({r_order, 1'b0}));
    assign w_bin_bad = NW'(i_request.index) >= w_n;
    assign w_load_bad = CMPW'(i_request.index) > CMPW'(MAX_ORDER);
    assign w_shift   = cgd_pkg::LOG2_W'(MAX_LOG2_FFT) - r_log2;
    assign w_idx_ph  = LOG'(i_request.index);
    assign w_step    = w_idx_ph << w_shift;
    assign w_order_m = MW'(r_order);
    assign w_issue   = (r_state == cgd_pkg::CGD_RUN);

    // saturation of the finished sum
    logic signed [EXT_W-1:0] w_acc_ext;
    logic signed [EXT_W-1:0] w_sat;
    always_comb begin
        w_acc_ext = EXT_W'(r_acc);
        if (w_acc_ext > VMAX) begin
            w_sat = VMAX;
        end else if (w_acc_ext < VMIN) begin
            w_sat = VMIN;
        end else begin
            w_sat = w_acc_ext;
        end
    end

    // next state and outputs
    always_comb begin
        n_state   = r_state;
        n_m       = r_m;
        n_phase   = r_phase;
        n_step    = r_step;
        n_done    = 1'b0;
        n_res     = r_res;
        w_acc_clr = 1'b0;
        w_we      = 1'b0;
        case (r_state)
            cgd_pkg::CGD_IDLE: begin
                if (w_accept) begin
                    n_res.value = '0;
                    if (i_request.kind == cgd_pkg::KIND_LOAD) begin
                        n_done = 1'b1;
                        if (w_load_bad) begin
                            n_res.status = cgd_pkg::STATUS_RANGE;
                        end else begin
                            n_res.status = cgd_pkg::STATUS_OK;
                            w_we         = 1'b1;
                        end
                    end else if (w_cfg_bad) begin
                        n_done       = 1'b1;
                        n_res.status = cgd_pkg::STATUS_CFG_INVALID;
                    end else if (w_bin_bad) begin
                        n_done       = 1'b1;
                        n_res.status = cgd_pkg::STATUS_RANGE;
                    end else if (r_order == '0) begin
                        n_done       = 1'b1;
                        n_res.status = cgd_pkg::STATUS_OK;
                    end else begin
                        n_state   = cgd_pkg::CGD_RUN;
                        n_m       = MW'(1);
                        n_phase   = w_step;
                        n_step    = w_step;
                        w_acc_clr = 1'b1;
                    end
                end
            end
            cgd_pkg::CGD_RUN: begin
                n_m     = r_m + MW'(1);
                n_phase = r_phase + r_step;
                if (r_m == w_order_m) begin
                    n_state = cgd_pkg::CGD_DRAIN;
                end
            end
            cgd_pkg::CGD_DRAIN: begin
                if (!r_vb && !r_vc && !r_vd) begin
                    n_state      = cgd_pkg::CGD_IDLE;
                    n_done       = 1'b1;
                    n_res.value  = w_sat[cgd_pkg::VALUE_W-1:0];
                    n_res.status = cgd_pkg::STATUS_OK;
                end
            end
            default: begin
                n_state = cgd_pkg::CGD_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cgd_pkg::CGD_IDLE;
            r_done  <= 1'b0;
            r_vb    <= 1'b0;
            r_vc    <= 1'b0;
            r_vd    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_vb    <= w_issue;
            r_vc    <= r_vb;
            r_vd    <= r_vc;
        end
    end

    // sequencer payload registers
    always_ff @(posedge i_clk) begin
        r_m     <= n_m;
        r_phase <= n_phase;
        r_step  <= n_step;
        r_res   <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    // coefficient store
    logic [cgd_pkg::COEF_W-1:0] mem [MAX_ORDER+1];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[MW'(i_request.index)] <= i_request.coef;
        end
        r_c <= mem[r_m];
    end

    // cosine for the current phase
    cgd_cos_rom #(
        .MAX_LOG2_FFT (MAX_LOG2_FFT)
    ) u_cos_rom (
        .i_clk   (i_clk),
        .i_phase (r_phase),
        .o_mag   (w_cos_mag),
        .o_neg   (w_cos_neg)
    );

    // m times coefficient, signed cosine alongside
    logic signed [COSS_W-1:0] w_mag_s;
    assign w_mag_s = $signed({1'b0, w_cos_mag});

    always_ff @(posedge i_clk) begin
        r_m_b   <= r_m;
        r_p1    <= $signed({1'b0, r_m_b}) * r_c;
        r_cos_c <= w_cos_neg ? -w_mag_s : w_mag_s;
        r_p2    <= r_p1 * r_cos_c;
    end

    // round to q20, halves upward, and accumulate
    logic signed [P2_W-1:0]   w_round;
    logic signed [TERM_W-1:0] w_term;
    assign w_round = r_p2 + P2_W'(32768);
    assign w_term  = w_round[P2_W-1:16];

    always_ff @(posedge i_clk) begin
        if (w_acc_clr) begin
            r_acc <= '0;
        end else if (r_vd) begin
            r_acc <= r_acc + ACC_W'(w_term);
        end
    end

    // checks
    `CGD_ASSERT(a_done_idle, i_clk, i_rst_n, o_done |-> !busy)
    `CGD_ASSERT_NEVER(a_acc_idle, i_clk, i_rst_n, r_vd && (r_state == cgd_pkg::CGD_IDLE))
    `CGD_ASSERT(a_issue_pipe, i_clk, i_rst_n, (r_state == cgd_pkg::CGD_RUN) |=> r_vb)
    `CGD_ASSERT(a_load_answer, i_clk, i_rst_n, (w_accept && (i_request.kind == cgd_pkg::KIND_LOAD)) |=> o_done)

endmodule

`default_nettype wire
